@@ rtl/core/utrb_pkg.sv @@
package utrb_pkg;

  // Field widths
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned LEVEL_W = 5;

  // Input item, last field in the lowest bits (24-bit tdata)
  typedef struct packed {
    logic [3:0]        pad;
    logic [BYTE_W-1:0] line_rx_byte;
    logic              line_rx_valid;
    logic              line_tx_idle;
    logic              host_read;
    logic [BYTE_W-1:0] host_write_byte;
    logic              host_write;
  } in_item_t;

  // Result item, last field in the lowest bits (32-bit tdata)
  typedef struct packed {
    logic [1:0]         pad;
    logic [LEVEL_W-1:0] rx_level;
    logic [LEVEL_W-1:0] tx_level;
    logic               rx_dropped;
    logic [BYTE_W-1:0]  line_tx_byte;
    logic               line_tx_start;
    logic [BYTE_W-1:0]  host_read_byte;
    logic               host_read_valid;
    logic               host_write_taken;
  } out_item_t;

  localparam int unsigned IN_W  = $bits(in_item_t);
  localparam int unsigned OUT_W = $bits(out_item_t);

endpackage

@@ rtl/core/uart_tx_rx_ring_buffer.sv @@
// UART transmit/receive ring buffer. Each transfer on the input stream is one
// clock step of the host/line interface: the line side (transmit pop, receive
// push) is handled first, then the host write (direct bypass to the line when
// the transmit queue is empty and the line is free, queued otherwise, refused
// when full) and the host read. One item is taken per clock unless the output
// stalls; its result is registered, and a new item is taken while that result
// waits as long as the output side takes it in the same cycle. Each queue is
// a QUEUE_DEPTH x 8 memory with one write and one registered read port, which
// keeps the queue head prefetched. Queue memories need no clearing after
// reset. The user must write block_enable (reset 1) through
// cfg_wr_en/cfg_wr_data only while the block is idle; it is not enforced.
module uart_tx_rx_ring_buffer #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  // configuration: block_enable
  input  logic                       cfg_wr_en,
  input  logic                       cfg_wr_data,
  // input items
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  // [0] host_write, [8:1] host_write_byte, [9] host_read, [10] line_tx_idle,
  // [11] line_rx_valid, [19:12] line_rx_byte, [23:20] zero
  input  logic [utrb_pkg::IN_W-1:0]  s_axis_tdata,
  // result items
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // [0] host_write_taken, [1] host_read_valid, [9:2] host_read_byte,
  // [10] line_tx_start, [18:11] line_tx_byte, [19] rx_dropped,
  // [24:20] tx_level, [29:25] rx_level, [31:30] zero
  output logic [utrb_pkg::OUT_W-1:0] m_axis_tdata
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(QUEUE_DEPTH - 1);

  // Control state
  logic             block_enable;
  logic             tx_service_on, rx_service_on;
  logic [PTR_W-1:0] tx_read_ptr, tx_write_ptr, rx_read_ptr, rx_write_ptr;
  logic [CNT_W-1:0] tx_count, rx_count;
  logic             out_valid;

  // Queue storage and prefetched heads
  logic [utrb_pkg::BYTE_W-1:0] tx_store [QUEUE_DEPTH];
  logic [utrb_pkg::BYTE_W-1:0] rx_store [QUEUE_DEPTH];
  logic [utrb_pkg::BYTE_W-1:0] tx_head, rx_head;

  utrb_pkg::in_item_t  item;
  utrb_pkg::out_item_t res, res_q;

  logic             step;
  logic             tx_pop, bypass, tx_push, rx_push, rx_pop;
  logic [CNT_W-1:0] tx_count_a, rx_count_a;
  logic             tx_svc_a, rx_svc_a;
  logic             tx_service_on_next, rx_service_on_next;
  logic [CNT_W-1:0] tx_count_next, rx_count_next;
  logic [PTR_W-1:0] tx_read_ptr_next, tx_write_ptr_next;
  logic [PTR_W-1:0] rx_read_ptr_next, rx_write_ptr_next;
  logic [PTR_W-1:0] tx_rd_addr, rx_rd_addr;

  assign item          = utrb_pkg::in_item_t'(s_axis_tdata);
  assign s_axis_tready = !out_valid || m_axis_tready;
  assign step          = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = res_q;

  // One step of the ring buffer
  always_comb begin
    // transmit service
    tx_pop     = tx_service_on && item.line_tx_idle && (tx_count != '0);
    tx_count_a = tx_count - CNT_W'(tx_pop);
    tx_svc_a   = tx_service_on;
    if (tx_service_on && item.line_tx_idle && (tx_count_a == '0)) begin
      tx_svc_a = 1'b0;
    end

    // receive service
    rx_push    = item.line_rx_valid && rx_service_on && (rx_count < DEPTH_CNT);
    rx_count_a = rx_count + CNT_W'(rx_push);
    rx_svc_a   = rx_service_on;
    if (rx_push && (rx_count_a >= DEPTH_CNT)) begin
      rx_svc_a = 1'b0;
    end

    // host write: bypass or queue
    bypass  = item.host_write && (tx_count_a == '0) && item.line_tx_idle && !tx_pop;
    tx_push = item.host_write && !bypass && (tx_count_a < DEPTH_CNT);
    tx_count_next      = tx_count_a + CNT_W'(tx_push);
    tx_service_on_next = (tx_push && block_enable) ? 1'b1 : tx_svc_a;

    // host read
    rx_pop             = item.host_read && (rx_count_a != '0);
    rx_count_next      = rx_count_a - CNT_W'(rx_pop);
    rx_service_on_next = (rx_pop && block_enable) ? 1'b1 : rx_svc_a;

    // pointers
    tx_read_ptr_next  = tx_read_ptr;
    tx_write_ptr_next = tx_write_ptr;
    rx_read_ptr_next  = rx_read_ptr;
    rx_write_ptr_next = rx_write_ptr;
    if (tx_pop) begin
      tx_read_ptr_next = (tx_read_ptr == PTR_LAST) ? '0 : tx_read_ptr + PTR_W'(1);
    end
    if (tx_push) begin
      tx_write_ptr_next = (tx_write_ptr == PTR_LAST) ? '0 : tx_write_ptr + PTR_W'(1);
    end
    if (rx_pop) begin
      rx_read_ptr_next = (rx_read_ptr == PTR_LAST) ? '0 : rx_read_ptr + PTR_W'(1);
    end
    if (rx_push) begin
      rx_write_ptr_next = (rx_write_ptr == PTR_LAST) ? '0 : rx_write_ptr + PTR_W'(1);
    end

    // result item
    res                  = '0;
    res.host_write_taken = bypass || tx_push;
    res.host_read_valid  = rx_pop;
    // an empty receive queue can only be read through this step's push
    if (rx_pop) begin
      res.host_read_byte = (rx_count == '0) ? item.line_rx_byte : rx_head;
    end
    res.line_tx_start = tx_pop || bypass;
    if (tx_pop) begin
      res.line_tx_byte = tx_head;
    end else if (bypass) begin
      res.line_tx_byte = item.host_write_byte;
    end
    res.rx_dropped = item.line_rx_valid && !rx_push;
    res.tx_level   = utrb_pkg::LEVEL_W'(tx_count_next);
    res.rx_level   = utrb_pkg::LEVEL_W'(rx_count_next);
  end

  // Read addresses of the head prefetch
  assign tx_rd_addr = step ? tx_read_ptr_next : tx_read_ptr;
  assign rx_rd_addr = step ? rx_read_ptr_next : rx_read_ptr;

  // Transmit queue memory with write-through on the head
  always_ff @(posedge clk) begin
    if (step && tx_push) begin
      tx_store[tx_write_ptr] <= item.host_write_byte;
    end
    if (step && tx_push && (tx_write_ptr == tx_rd_addr)) begin
      tx_head <= item.host_write_byte;
    end else begin
      tx_head <= tx_store[tx_rd_addr];
    end
  end

  // Receive queue memory with write-through on the head
  always_ff @(posedge clk) begin
    if (step && rx_push) begin
      rx_store[rx_write_ptr] <= item.line_rx_byte;
    end
    if (step && rx_push && (rx_write_ptr == rx_rd_addr)) begin
      rx_head <= item.line_rx_byte;
    end else begin
      rx_head <= rx_store[rx_rd_addr];
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      block_enable  <= 1'b1;
      tx_service_on <= 1'b0;
      rx_service_on <= 1'b1;
      tx_read_ptr   <= '0;
      tx_write_ptr  <= '0;
      tx_count      <= '0;
      rx_read_ptr   <= '0;
      rx_write_ptr  <= '0;
      rx_count      <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        block_enable  <= cfg_wr_data;
        rx_service_on <= cfg_wr_data && (rx_count < DEPTH_CNT);
        tx_service_on <= cfg_wr_data && (tx_count != '0);
      end else if (step) begin
        tx_service_on <= tx_service_on_next;
        rx_service_on <= rx_service_on_next;
      end
      if (step) begin
        tx_read_ptr  <= tx_read_ptr_next;
        tx_write_ptr <= tx_write_ptr_next;
        tx_count     <= tx_count_next;
        rx_read_ptr  <= rx_read_ptr_next;
        rx_write_ptr <= rx_write_ptr_next;
        rx_count     <= rx_count_next;
        out_valid    <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (step) begin
      res_q <= res;
    end
  end

  // Checks
  a_tx_count_range: assert property (@(posedge clk) disable iff (rst)
    tx_count <= DEPTH_CNT && rx_count <= DEPTH_CNT)
    else $error("queue count beyond depth");

  a_disabled_services_off: assert property (@(posedge clk) disable iff (rst)
    !block_enable |-> (!tx_service_on && !rx_service_on))
    else $error("service on while block disabled");

  a_rx_service_room: assert property (@(posedge clk) disable iff (rst)
    rx_service_on |-> (rx_count < DEPTH_CNT))
    else $error("receive service on with full queue");

  a_tx_service_pending: assert property (@(posedge clk) disable iff (rst)
    tx_service_on |-> (tx_count != '0))
    else $error("transmit service on with empty queue");

endmodule

@@ tb/uart_tx_rx_ring_buffer_tb.sv @@
module uart_tx_rx_ring_buffer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned QDEPTH = 16;

  // Tracks both queues and the service flags; one expected result per step
  class utrb_scoreboard;
    bit                          enable = 1'b1;
    logic [utrb_pkg::BYTE_W-1:0] tx_mem [QDEPTH];
    logic [utrb_pkg::BYTE_W-1:0] rx_mem [QDEPTH];
    int unsigned                 tx_rd, tx_wr, tx_cnt;
    int unsigned                 rx_rd, rx_wr, rx_cnt;
    bit                          tx_on = 1'b0;
    bit                          rx_on = 1'b1;
    utrb_pkg::out_item_t         expected_steps[$];
    int unsigned                 errors, checked;
    int unsigned                 n_direct, n_refused, n_dropped, n_reads, n_full;

    function int unsigned pending();
      return expected_steps.size();
    endfunction

    // register write, block idle
    function void set_enable(bit v);
      enable = v;
      if (v) begin
        rx_on = (rx_cnt < QDEPTH);
        tx_on = (tx_cnt > 0);
      end else begin
        rx_on = 1'b0;
        tx_on = 1'b0;
      end
    endfunction

    // one clock step of the host/line interface
    function utrb_pkg::out_item_t step_queues(utrb_pkg::in_item_t it);
      utrb_pkg::out_item_t r;
      r = '0;
      // line transmit: pop head when idle
      if (tx_on && it.line_tx_idle) begin
        if (tx_cnt > 0) begin
          r.line_tx_start = 1'b1;
          r.line_tx_byte  = tx_mem[tx_rd];
          tx_rd           = (tx_rd + 1) % QDEPTH;
          tx_cnt--;
        end
        if (tx_cnt == 0) tx_on = 1'b0;
      end
      // line receive
      if (it.line_rx_valid) begin
        if (rx_on && rx_cnt < QDEPTH) begin
          rx_mem[rx_wr] = it.line_rx_byte;
          rx_wr         = (rx_wr + 1) % QDEPTH;
          rx_cnt++;
          if (rx_cnt >= QDEPTH) rx_on = 1'b0;
        end else begin
          r.rx_dropped = 1'b1;
        end
      end
      // host write: bypass only if the line was not started above
      if (it.host_write) begin
        if (tx_cnt == 0 && it.line_tx_idle && !r.line_tx_start) begin
          r.line_tx_start    = 1'b1;
          r.line_tx_byte     = it.host_write_byte;
          r.host_write_taken = 1'b1;
        end else if (tx_cnt < QDEPTH) begin
          tx_mem[tx_wr]      = it.host_write_byte;
          tx_wr              = (tx_wr + 1) % QDEPTH;
          tx_cnt++;
          r.host_write_taken = 1'b1;
          if (enable) tx_on = 1'b1;
        end
      end
      // host read
      if (it.host_read && rx_cnt > 0) begin
        r.host_read_valid = 1'b1;
        r.host_read_byte  = rx_mem[rx_rd];
        rx_rd             = (rx_rd + 1) % QDEPTH;
        rx_cnt--;
        if (enable) rx_on = 1'b1;
      end
      r.tx_level = tx_cnt[utrb_pkg::LEVEL_W-1:0];
      r.rx_level = rx_cnt[utrb_pkg::LEVEL_W-1:0];
      return r;
    endfunction

    function void note_step(utrb_pkg::in_item_t it);
      utrb_pkg::out_item_t r;
      r = step_queues(it);
      if (it.host_write && r.line_tx_start && !(tx_cnt > 0) && r.host_write_taken &&
          it.line_tx_idle && r.line_tx_byte == it.host_write_byte)
        n_direct++;
      if (it.host_write && !r.host_write_taken) n_refused++;
      if (r.rx_dropped) n_dropped++;
      if (r.host_read_valid) n_reads++;
      if (tx_cnt == QDEPTH || rx_cnt == QDEPTH) n_full++;
      expected_steps.push_back(r);
    endfunction

    function string describe(utrb_pkg::out_item_t r);
      return $sformatf({"taken=%0b rd_valid=%0b rd_byte=%02h tx_start=%0b ",
                        "tx_byte=%02h dropped=%0b tx_level=%0d rx_level=%0d"},
                       r.host_write_taken, r.host_read_valid, r.host_read_byte,
                       r.line_tx_start, r.line_tx_byte, r.rx_dropped,
                       r.tx_level, r.rx_level);
    endfunction

    function void note_error(string msg);
      errors++;
      if (errors <= 10) $display("MISMATCH: %s", msg);
    endfunction

    function void check_step(utrb_pkg::out_item_t got);
      utrb_pkg::out_item_t want;
      if (expected_steps.size() == 0) begin
        note_error($sformatf("unexpected result %s", describe(got)));
        return;
      end
      want = expected_steps.pop_front();
      if (got.host_write_taken !== want.host_write_taken ||
          got.host_read_valid  !== want.host_read_valid  ||
          got.host_read_byte   !== want.host_read_byte   ||
          got.line_tx_start    !== want.line_tx_start    ||
          got.line_tx_byte     !== want.line_tx_byte     ||
          got.rx_dropped       !== want.rx_dropped       ||
          got.tx_level         !== want.tx_level         ||
          got.rx_level         !== want.rx_level)
        note_error($sformatf("result %0d: expected %s, got %s", checked,
                             describe(want), describe(got)));
      checked++;
    endfunction

    function void flag_leftovers();
      if (expected_steps.size() != 0)
        note_error($sformatf("%0d results never arrived", expected_steps.size()));
    endfunction
  endclass

  logic                       clk;
  logic                       rst;
  logic                       cfg_wr_en;
  logic                       cfg_wr_data;
  logic                       s_axis_tvalid;
  logic                       s_axis_tready;
  logic [utrb_pkg::IN_W-1:0]  s_axis_tdata;   // host_write, host_write_byte, host_read,
                                              // line_tx_idle, line_rx_valid, line_rx_byte
  logic                       m_axis_tvalid;
  logic                       m_axis_tready;
  logic [utrb_pkg::OUT_W-1:0] m_axis_tdata;   // host_write_taken, host_read_valid,
                                              // host_read_byte, line_tx_start,
                                              // line_tx_byte, rx_dropped, tx_level,
                                              // rx_level

  utrb_scoreboard sb = new();
  int unsigned    burst_left;
  int unsigned    n_cfg;

  uart_tx_rx_ring_buffer #(
    .QUEUE_DEPTH (QDEPTH)
  ) u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // 12 ns clock
  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // mostly short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic utrb_pkg::in_item_t mk_step(bit wr, logic [7:0] wr_byte, bit rd,
                                                 bit idle, bit rxv, logic [7:0] rx_byte);
    utrb_pkg::in_item_t it;
    it                 = '0;
    it.host_write      = wr;
    it.host_write_byte = wr_byte;
    it.host_read       = rd;
    it.line_tx_idle    = idle;
    it.line_rx_valid   = rxv;
    it.line_rx_byte    = rx_byte;
    return it;
  endfunction

  function automatic utrb_pkg::in_item_t rand_step(int unsigned p_wr, int unsigned p_rd,
                                                   int unsigned p_idle,
                                                   int unsigned p_rxv);
    return mk_step($urandom_range(0, 99) < p_wr, 8'($urandom_range(0, 255)),
                   $urandom_range(0, 99) < p_rd, $urandom_range(0, 99) < p_idle,
                   $urandom_range(0, 99) < p_rxv, 8'($urandom_range(0, 255)));
  endfunction

  // one input transfer; called and returns at a falling edge
  task automatic send_step(utrb_pkg::in_item_t it);
    int unsigned gap;
    if (burst_left > 0) begin
      gap = 0;
      burst_left--;
    end else begin
      gap = pick_gap();
      if ($urandom_range(0, 40) == 0) burst_left = $urandom_range(20, 80);
    end
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = it;
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
  endtask

  // stop sending and wait for every outstanding result
  task automatic wait_drained();
    s_axis_tvalid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_enable(bit v);
    wait_drained();
    cfg_wr_en   = 1'b1;
    cfg_wr_data = v;
    @(negedge clk);
    cfg_wr_en   = 1'b0;
    sb.set_enable(v);
    n_cfg++;
  endtask

  // transfers seen at the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) sb.check_step(m_axis_tdata);
      if (s_axis_tvalid && s_axis_tready) sb.note_step(s_axis_tdata);
    end
  end

  // output side back-pressure
  initial begin : sink_pacing
    int unsigned run, stall;
    m_axis_tready = 1'b0;
    @(negedge clk);
    forever begin
      run = $urandom_range(1, 40);
      m_axis_tready = 1'b1;
      repeat (run) @(negedge clk);
      stall = pick_gap();
      if (stall > 0) begin
        m_axis_tready = 1'b0;
        repeat (stall) @(negedge clk);
      end
    end
  end

  // per-phase enable value and event odds in percent
  bit          ph_en   [6] = '{1, 0, 1, 1, 0, 1};
  int unsigned ph_wr   [6] = '{50, 60, 25, 75, 40, 50};
  int unsigned ph_rd   [6] = '{50, 15, 75, 15, 60, 50};
  int unsigned ph_idle [6] = '{50, 20, 75, 15, 60, 85};
  int unsigned ph_rxv  [6] = '{50, 70, 30, 80, 40, 50};

  initial begin : stimulus
    int unsigned k;
    rst           = 1'b1;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    burst_left    = 0;
    n_cfg         = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: bypass, queueing, same-cycle pop vs write, empty read
    send_step(mk_step(0, 8'h00, 0, 0, 0, 8'h00));
    send_step(mk_step(1, 8'hFF, 0, 1, 0, 8'h00));
    send_step(mk_step(1, 8'h00, 0, 0, 0, 8'h00));
    send_step(mk_step(1, 8'hA5, 1, 0, 1, 8'hFF));
    send_step(mk_step(1, 8'h5A, 0, 1, 1, 8'h00));
    send_step(mk_step(0, 8'h00, 1, 1, 0, 8'h00));
    send_step(mk_step(1, 8'h3C, 0, 1, 0, 8'h00));
    send_step(mk_step(0, 8'h00, 1, 1, 0, 8'h00));
    send_step(mk_step(1, 8'h81, 0, 1, 0, 8'h00));
    // fill both queues past full: refused writes, dropped rx bytes
    for (k = 0; k < 18; k++)
      send_step(mk_step(1, 8'($urandom_range(0, 255)), 0, 0, 1,
                        8'($urandom_range(0, 255))));
    // disable, then re-enable with rx full and tx pending
    write_enable(1'b0);
    write_enable(1'b1);

    // random phases across enable settings and traffic mixes
    for (int ph = 0; ph < 6; ph++) begin
      write_enable(ph_en[ph]);
      for (k = 0; k < 125; k++)
        send_step(rand_step(ph_wr[ph], ph_rd[ph], ph_idle[ph], ph_rxv[ph]));
    end

    // drain, bounded
    s_axis_tvalid = 1'b0;
    k = 0;
    while (sb.pending() != 0 && k < 5000) begin
      @(negedge clk);
      k++;
    end
    repeat (8) @(negedge clk);
    sb.flag_leftovers();

    $display("Checked %0d steps over %0d enable writes; %0d mismatches.",
             sb.checked, n_cfg, sb.errors);
    $display({"Seen: %0d direct sends, %0d refused writes, %0d dropped rx bytes, ",
              "%0d reads, %0d full-queue steps."},
             sb.n_direct, sb.n_refused, sb.n_dropped, sb.n_reads, sb.n_full);
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // hard stop
  initial begin : watchdog
    #6_000_000;
    $display("Timeout with %0d results outstanding.", sb.pending());
    $display("TB_ERROR");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/utrb_pkg.sv
rtl/core/uart_tx_rx_ring_buffer.sv
tb/uart_tx_rx_ring_buffer_tb.sv
